FILE: rtl/plc_pkg.sv
// Shared types and constants of the polygon plane clipper.
// Used by every module of the block; depends on nothing else.
package plc_pkg;

   localparam int CW       = 32;
   localparam int NCOMP    = 6;
   localparam int SFRAC    = 24;
   localparam int DIST_W   = 52;
   localparam int QUOT_W   = SFRAC + 1;
   localparam int CSR_IW   = 3;
   localparam int CSR_DW   = 64;
   localparam int MIN_KEEP = 3;

   localparam logic [CSR_IW-1:0] REG_PLANE_COUNT = 3'd0;
   localparam logic [CSR_IW-1:0] REG_PLANE_0     = 3'd1;

   typedef logic [NCOMP-1:0][CW-1:0] vtx_type;

   typedef struct packed {
      logic signed [CW-1:0] pos_x;
      logic signed [CW-1:0] pos_y;
      logic signed [CW-1:0] pos_z;
      logic signed [CW-1:0] pos_w;
      logic signed [CW-1:0] tex_u;
      logic signed [CW-1:0] tex_v;
      logic                 last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] out_x;
      logic signed [CW-1:0] out_y;
      logic signed [CW-1:0] out_z;
      logic signed [CW-1:0] out_w;
      logic signed [CW-1:0] out_u;
      logic signed [CW-1:0] out_v;
      logic                 last_out;
      logic                 keep;
      logic                 overflow;
   } rsp_type;

endpackage

FILE: rtl/polygon_plane_clipper_unit.sv
// Polygon plane clipper: Sutherland-Hodgman clipping of one polygon against up
// to six planes held in the CSRs. Depends on plc_pkg, plc_queue and plc_div.
// Vertices are taken one per cycle; the request that carries last_vertex starts
// clipping, during which no request is taken. Each plane has a setup step, then
// per edge a vertex fetch, the four-step serial plane distance, a decision and
// an advance; a crossing edge also passes the bit-serial divider, the shared
// interpolation multiplier and one or two pushes. The clipped polygon then
// leaves at one vertex per cycle unless rsp_ready stalls the output. The vertex
// queue is a row of cells that shift toward the head on every pop.
module polygon_plane_clipper_unit #(
   parameter int MAX_VERTS  = 32,
   parameter int MAX_PLANES = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  plc_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output plc_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [plc_pkg::CSR_IW-1:0]   csr_index,
   input  logic [plc_pkg::CSR_DW-1:0]   csr_wdata
);
   import plc_pkg::*;

   localparam int QD = 2 * MAX_VERTS;
   localparam int QW = $clog2(QD + 1);
   localparam int MW = $clog2(MAX_VERTS + 1);

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_PLANE = 4'd1;
   localparam logic [3:0] S_DA    = 4'd2;
   localparam logic [3:0] S_GETB  = 4'd3;
   localparam logic [3:0] S_DB    = 4'd4;
   localparam logic [3:0] S_DEC   = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_IMUL  = 4'd7;
   localparam logic [3:0] S_IADD  = 4'd8;
   localparam logic [3:0] S_PUSHC = 4'd9;
   localparam logic [3:0] S_PUSHB = 4'd10;
   localparam logic [3:0] S_NEXT  = 4'd11;
   localparam logic [3:0] S_EMIT  = 4'd12;
   localparam logic [3:0] S_REJ   = 4'd13;

   logic [3:0]        state_ff, state_in;
   logic [2:0]        pcount_ff;
   logic [CSR_DW-1:0] plane_ff [MAX_PLANES];
   logic [2:0]        plane_idx_ff, plane_idx_in;
   logic [2:0]        nplanes;

   vtx_type a_ff, a_in, b_ff, b_in, f_ff, f_in, c_ff, c_in;
   logic signed [DIST_W-1:0] da_ff, da_in, db_ff, db_in, acc_ff, acc_in;
   logic [1:0]        j_ff, j_in;
   logic [2:0]        k_ff, k_in;
   logic [QW-1:0]     n_ff, n_in, i_ff, i_in;
   logic [MW-1:0]     m_ff, m_in;
   logic              ovf_ff, ovf_in;
   logic [57:0]       prod_ff, prod_in;
   logic              neg_ff, neg_in;

   logic              q_clear, q_pop, q_push;
   vtx_type           q_push_vtx, q_head, in_vtx;
   logic [QW-1:0]     q_count;

   logic              div_start, div_done;
   logic [QUOT_W-1:0] div_quot;
   logic [QUOT_W-1:0] s_ff, s_in;
   logic [DIST_W-1:0] num, den;
   logic signed [DIST_W-1:0] df;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              out_free;

   logic [CSR_DW-1:0]        plane_sel;
   vtx_type                  dist_vtx;
   logic signed [15:0]       coef;
   logic signed [47:0]       dprod;
   logic signed [DIST_W-1:0] dsum;
   logic signed [CW:0]       diff;
   logic [CW:0]              mag;
   logic [33:0]              qround;
   logic signed [33:0]       interp;
   logic                     ain, bin;

   plc_queue #(.DEPTH(QD), .QW(QW)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .clear    (q_clear),
      .pop      (q_pop),
      .push     (q_push),
      .push_vtx (q_push_vtx),
      .head     (q_head),
      .count    (q_count)
   );

   plc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= '0;
         for (int p = 0; p < MAX_PLANES; p++) begin
            plane_ff[p] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == REG_PLANE_COUNT) begin
            pcount_ff <= csr_wdata[2:0];
         end
         for (int p = 0; p < MAX_PLANES; p++) begin
            if (csr_index == REG_PLANE_0 + CSR_IW'(p)) begin
               plane_ff[p] <= csr_wdata;
            end
         end
      end
   end

   assign nplanes   = (pcount_ff > 3'(MAX_PLANES)) ? 3'(MAX_PLANES) : pcount_ff;
   assign plane_sel = plane_ff[plane_idx_ff];
   assign dist_vtx  = (state_ff == S_DA) ? a_ff : b_ff;
   assign coef      = $signed(plane_sel[16*j_ff +: 16]);
   assign dprod     = coef * $signed(dist_vtx[j_ff]);
   assign dsum      = ((j_ff == 2'd0) ? DIST_W'(0) : acc_ff) + DIST_W'(dprod);

   assign ain = da_ff[DIST_W-1];
   assign bin = db_ff[DIST_W-1];
   assign df  = da_ff - db_ff;
   assign num = ain ? DIST_W'(-da_ff) : DIST_W'(da_ff);
   assign den = df[DIST_W-1] ? DIST_W'(-df) : DIST_W'(df);

   assign diff   = $signed({b_ff[k_ff][CW-1], b_ff[k_ff]})
                 - $signed({a_ff[k_ff][CW-1], a_ff[k_ff]});
   assign mag    = diff[CW] ? (CW+1)'(0) - diff : diff;
   assign qround = 34'((prod_ff + (58'd1 << (SFRAC - 1))) >> SFRAC);
   assign interp = $signed({{2{a_ff[k_ff][CW-1]}}, a_ff[k_ff]})
                 + (neg_ff ? -$signed(qround) : $signed(qround));

   assign in_vtx = {req_data.tex_v, req_data.tex_u, req_data.pos_w,
                    req_data.pos_z, req_data.pos_y, req_data.pos_x};
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      plane_idx_in = plane_idx_ff;
      a_in = a_ff; b_in = b_ff; f_in = f_ff; c_in = c_ff;
      da_in = da_ff; db_in = db_ff; acc_in = acc_ff;
      j_in = j_ff; k_in = k_ff; n_in = n_ff; i_in = i_ff; m_in = m_ff;
      ovf_in = ovf_ff; prod_in = prod_ff; neg_in = neg_ff; s_in = s_ff;
      q_clear = 1'b0; q_pop = 1'b0; q_push = 1'b0; q_push_vtx = b_ff;
      div_start = 1'b0;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;

      unique case (state_ff) inside
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (q_count < QW'(MAX_VERTS)) begin
                  q_push     = 1'b1;
                  q_push_vtx = in_vtx;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_vertex) begin
                  plane_idx_in = '0;
                  state_in     = S_PLANE;
               end
            end
         end
         S_PLANE: begin
            n_in = q_count;
            m_in = '0;
            i_in = '0;
            j_in = '0;
            if (plane_idx_ff == nplanes) begin
               state_in = (q_count < QW'(MIN_KEEP)) ? S_REJ : S_EMIT;
            end else if (q_count == '0) begin
               plane_idx_in = plane_idx_ff + 1'b1;
            end else begin
               q_pop    = 1'b1;
               a_in     = q_head;
               f_in     = q_head;
               state_in = S_DA;
            end
         end
         S_DA, S_DB: begin
            acc_in = dsum;
            j_in   = j_ff + 1'b1;
            if (j_ff == 2'd3) begin
               if (state_ff == S_DA) begin
                  da_in    = dsum;
                  state_in = S_GETB;
               end else begin
                  db_in    = dsum;
                  state_in = S_DEC;
               end
            end
         end
         S_GETB: begin
            if (i_ff == n_ff - 1'b1) begin
               b_in = f_ff;
            end else begin
               q_pop = 1'b1;
               b_in  = q_head;
            end
            j_in     = '0;
            state_in = S_DB;
         end
         S_DEC: begin
            if (ain && bin) begin
               q_push_vtx = b_ff;
               if (m_ff < MW'(MAX_VERTS)) begin
                  q_push = 1'b1;
                  m_in   = m_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               state_in = S_NEXT;
            end else if (ain != bin) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_DIV: begin
            if (div_done) begin
               s_in     = div_quot;
               k_in     = '0;
               state_in = S_IMUL;
            end
         end
         S_IMUL: begin
            prod_in  = 58'(mag) * 58'(s_ff);
            neg_in   = diff[CW];
            state_in = S_IADD;
         end
         S_IADD: begin
            c_in[k_ff] = interp[CW-1:0];
            if (k_ff == 3'(NCOMP - 1)) begin
               state_in = S_PUSHC;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_IMUL;
            end
         end
         S_PUSHC, S_PUSHB: begin
            q_push_vtx = (state_ff == S_PUSHC) ? c_ff : b_ff;
            if (m_ff < MW'(MAX_VERTS)) begin
               q_push = 1'b1;
               m_in   = m_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
            state_in = (state_ff == S_PUSHC && bin) ? S_PUSHB : S_NEXT;
         end
         S_NEXT: begin
            a_in  = b_ff;
            da_in = db_ff;
            if (i_ff == n_ff - 1'b1) begin
               plane_idx_in = plane_idx_ff + 1'b1;
               state_in     = S_PLANE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_GETB;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               q_pop        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = {q_head[0], q_head[1], q_head[2], q_head[3], q_head[4],
                               q_head[5], q_count == QW'(1), 1'b1, ovf_ff};
               if (q_count == QW'(1)) begin
                  ovf_in   = 1'b0;
                  state_in = S_LOAD;
               end
            end
         end
         S_REJ: begin
            if (out_free) begin
               q_clear      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.last_out = 1'b1;
               rsp_in.overflow = ovf_ff;
               ovf_in       = 1'b0;
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         m_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         m_ff         <= m_in;
      end
   end

   always_ff @(posedge clock) begin
      plane_idx_ff <= plane_idx_in;
      a_ff <= a_in; b_ff <= b_in; f_ff <= f_in; c_ff <= c_in;
      da_ff <= da_in; db_ff <= db_in; acc_ff <= acc_in;
      j_ff <= j_in; k_ff <= k_in; n_ff <= n_in; i_ff <= i_in;
      prod_ff <= prod_in; neg_ff <= neg_in; s_ff <= s_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_ready_only_loading: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_LOAD) else $error("Request taken while clipping.");
   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      m_ff <= MW'(MAX_VERTS)) else $error("Clip pass produced too many vertices.");
   a_div_waits: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV) else $error("Divider finished out of turn.");
`endif

endmodule

FILE: rtl/plc_cell.sv
// One vertex cell of the polygon queue.
// Depends on plc_pkg for the vertex type.
module plc_cell (
   input  logic             clock,
   input  logic             shift,
   input  logic             load,
   input  plc_pkg::vtx_type next_vtx,
   input  plc_pkg::vtx_type wr_vtx,
   output plc_pkg::vtx_type vtx
);
   import plc_pkg::*;

   vtx_type vtx_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         vtx_ff <= wr_vtx;
      end else if (shift) begin
         vtx_ff <= next_vtx;
      end
   end

   assign vtx = vtx_ff;

endmodule

FILE: rtl/plc_queue.sv
// Polygon vertex queue built as a row of plc_cell instances.
// Pops shift every cell toward the head; pushes write at the tail.
// Depends on plc_pkg and plc_cell.
module plc_queue #(
   parameter int DEPTH = 64,
   parameter int QW    = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             pop,
   input  logic             push,
   input  plc_pkg::vtx_type push_vtx,
   output plc_pkg::vtx_type head,
   output logic [QW-1:0]    count
);
   import plc_pkg::*;

   vtx_type cell_vtx [DEPTH];
   logic [QW-1:0] count_ff;
   logic [QW-1:0] count_in;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      vtx_type next_vtx;
      if (i == DEPTH - 1) begin : g_end
         assign next_vtx = cell_vtx[i];
      end else begin : g_mid
         assign next_vtx = cell_vtx[i+1];
      end
      plc_cell u_cell (
         .clock    (clock),
         .shift    (pop),
         .load     (push && (count_ff == QW'(i))),
         .next_vtx (next_vtx),
         .wr_vtx   (push_vtx),
         .vtx      (cell_vtx[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (pop) begin
         count_in = count_ff - 1'b1;
      end else if (push) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head  = cell_vtx[0];
   assign count = count_ff;

`ifndef SYNTHESIS
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0) else $error("Pop from an empty vertex queue.");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff < QW'(DEPTH)) else $error("Push into a full vertex queue.");
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(push && pop)) else $error("Push and pop in the same cycle.");
`endif

endmodule

FILE: rtl/plc_div.sv
// Restoring divider: min(2^24, floor(num*2^24/den)), one quotient bit per cycle.
// Depends on plc_pkg for the widths.
module plc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [plc_pkg::DIST_W-1:0]   num,
   input  logic [plc_pkg::DIST_W-1:0]   den,
   output logic                         done,
   output logic [plc_pkg::QUOT_W-1:0]   quot
);
   import plc_pkg::*;

   logic [DIST_W:0]   rem_ff;
   logic [DIST_W-1:0] den_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [4:0]        step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DIST_W:0]   shifted;
   logic              fits;

   assign shifted = {rem_ff[DIST_W-1:0], 1'b0};
   assign fits    = shifted >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (num >= den) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff && step_ff == 5'(SFRAC - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= {1'b0, num};
         den_ff  <= den;
         step_ff <= '0;
         quot_ff <= (num >= den) ? QUOT_W'(1) << SFRAC : '0;
      end else if (busy_ff) begin
         rem_ff  <= fits ? shifted - {1'b0, den_ff} : shifted;
         quot_ff <= {quot_ff[QUOT_W-2:0], fits};
         step_ff <= step_ff + 1'b1;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
